[design/lagrange_basis_weights_core_assert.svh]
// Assertion macros shared by the Lagrange basis weight core.
`ifndef LAGRANGE_BASIS_WEIGHTS_CORE_ASSERT_SVH
`define LAGRANGE_BASIS_WEIGHTS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LGW_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LGW_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lgw_pkg.sv]
// Shared types, node tables and reciprocal tables for the Lagrange basis weight core.
package lgw_pkg;

  localparam int POINT_W     = 20;
  localparam int IN_TDATA_W  = 24;
  localparam int IDX_W       = 3;
  localparam int DEG_W       = 3;
  localparam int RES_W       = 32;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_FRAC    = 20;
  localparam int N_TBL       = 6;
  localparam int NODE_W      = 21;
  localparam int RECIP_W     = 29;
  localparam int CLAMP_W     = 34;

  localparam logic [DEG_W-1:0] DEG_RESET = 3'd2;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic [DEG_W-1:0] deg;
    logic             last;
  } tok_ctl_t;

  typedef logic [0:N_TBL-1][0:N_TBL-1][31:0]        node_rom_t;
  typedef logic [0:N_TBL-1][0:N_TBL-1][NODE_W-1:0]  node_tbl_t;
  typedef logic [0:N_TBL-1][0:N_TBL-1][RECIP_W-1:0] recip_tbl_t;

  // Gauss-Lobatto nodes in unsigned Q2.30, one row per degree.
  localparam node_rom_t NODE_ROM = '{
    '{32'd0, 32'd0,         32'd0,         32'd0,         32'd0,         32'd0},
    '{32'd0, 32'd1073741824, 32'd0,        32'd0,         32'd0,         32'd0},
    '{32'd0, 32'd536870912, 32'd1073741824, 32'd0,        32'd0,         32'd0},
    '{32'd0, 32'd296774941, 32'd776966883, 32'd1073741824, 32'd0,        32'd0},
    '{32'd0, 32'd185406399, 32'd536870912, 32'd888335425, 32'd1073741824, 32'd0},
    '{32'd0, 32'd126134963, 32'd383738408, 32'd690003416, 32'd947606861,
      32'd1073741824}
  };

  // Nodes rounded to Q.20, half toward plus infinity.
  function automatic node_tbl_t node_table();
    node_tbl_t tbl;
    logic [31:0] v;
    tbl = '0;
    for (int d = 0; d < N_TBL; d++) begin
      for (int k = 0; k < N_TBL; k++) begin
        v = (NODE_ROM[d][k] + 32'd512) >> 10;
        tbl[d][k] = v[NODE_W-1:0];
      end
    end
    return tbl;
  endfunction

  // Signed Q.20 reciprocal of each node's denominator product; shift-subtract
  // long division, evaluated at elaboration.
  function automatic recip_tbl_t recip_table();
    recip_tbl_t tbl;
    logic signed [63:0] den;
    logic signed [63:0] diff;
    logic signed [63:0] prod;
    logic signed [63:0] rs;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    tbl = '0;
    for (int d = 0; d < N_TBL; d++) begin
      for (int i = 0; i <= d; i++) begin
        den = 64'sd1073741824;
        for (int j = 0; j <= d; j++) begin
          if (j != i) begin
            diff = $signed({32'd0, NODE_ROM[d][i]}) - $signed({32'd0, NODE_ROM[d][j]});
            prod = den * diff;
            den  = (prod + 64'sd536870912) >>> 30;
          end
        end
        mag = (den < 0) ? 64'(-den) : 64'(den);
        num = (64'd1 << 50) + (mag >> 1);
        rem = '0;
        q   = '0;
        for (int b = 51; b >= 0; b--) begin
          rem = {rem[62:0], num[b]};
          if (rem >= mag) begin
            rem  = rem - mag;
            q[b] = 1'b1;
          end
        end
        rs = (den < 0) ? -$signed(q) : $signed(q);
        tbl[d][i] = rs[RECIP_W-1:0];
      end
    end
    return tbl;
  endfunction

  localparam node_tbl_t  NODE20_TBL = node_table();
  localparam recip_tbl_t RECIP_TBL  = recip_table();

endpackage

[design/lgw_issue.sv]
// Point intake and node sequencer: holds one point's factors and issues one token per node.
module lgw_issue #(
  parameter int MAX_DEGREE = 5,
  parameter int FRAC_BITS  = 16,
  parameter int N          = 6,
  parameter int S20W       = 24,
  parameter int FW         = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lgw_pkg::POINT_W-1:0]    in_point,
  input  logic [lgw_pkg::DEG_W-1:0]      degree,
  output lgw_pkg::tok_ctl_t              ctl_out,
  output logic signed [FW-1:0]           f_out [N]
);

  localparam int PW1 = lgw_pkg::POINT_W + 1;

  logic                          busy_r;
  logic [lgw_pkg::IDX_W-1:0]     idx_r;
  logic [lgw_pkg::DEG_W-1:0]     deg_r;
  logic signed [FW-1:0]          f_r [N];
  logic signed [FW-1:0]          f_nxt [N];
  logic [lgw_pkg::DEG_W-1:0]     deg_eff;
  logic signed [lgw_pkg::POINT_W-1:0] pnt;
  logic signed [S20W-1:0]        s20;
  logic                          last_tok;
  logic                          take;

  assign pnt = $signed(in_point);

  // Bring the point to Q.20: exact left shift, or round half up when finer.
  if (FRAC_BITS <= lgw_pkg::OUT_FRAC) begin : g_up
    assign s20 = S20W'(pnt) <<< (lgw_pkg::OUT_FRAC - FRAC_BITS);
  end else begin : g_dn
    localparam int SH = FRAC_BITS - lgw_pkg::OUT_FRAC;
    logic signed [PW1-1:0] t;
    assign t   = PW1'(pnt) + (PW1'(1) <<< (SH - 1));
    assign s20 = S20W'(t >>> SH);
  end

  assign deg_eff  = (degree > lgw_pkg::DEG_W'(MAX_DEGREE)) ?
                    lgw_pkg::DEG_W'(MAX_DEGREE) : degree;
  assign last_tok = (idx_r == deg_r);
  assign in_tready = !busy_r || (adv && last_tok);
  assign take     = in_tvalid && in_tready;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      f_nxt[k] = FW'(s20) - FW'($signed({1'b0, lgw_pkg::NODE20_TBL[deg_eff][k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      deg_r  <= '0;
    end else if (take) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      deg_r  <= deg_eff;
    end else if (adv && busy_r) begin
      idx_r <= idx_r + 1'b1;
      if (last_tok) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_r <= f_nxt;
    end
  end

  assign ctl_out.vld  = busy_r;
  assign ctl_out.idx  = idx_r;
  assign ctl_out.deg  = deg_r;
  assign ctl_out.last = last_tok;
  assign f_out        = f_r;

endmodule

[design/lgw_cell.sv]
// One chain cell: multiplies each active product lane by this cell's factor over two stages.
module lgw_cell #(
  parameter int K  = 0,
  parameter int N  = 6,
  parameter int FW = 25,
  parameter int LW = 42
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  lgw_pkg::tok_ctl_t    ctl_in,
  input  logic signed [FW-1:0] f_in [N],
  input  logic signed [LW-1:0] lane_in [N],
  output lgw_pkg::tok_ctl_t    ctl_out,
  output logic signed [FW-1:0] f_out [N],
  output logic signed [LW-1:0] lane_out [N]
);

  localparam int LL  = LW / 2;
  localparam int LH  = LW - LL;
  localparam int PHW = LH + FW;
  localparam int PLW = LL + 1 + FW;
  localparam int PW  = LW + FW + 1;
  localparam logic signed [PW-1:0] RND_C = PW'(1) <<< (lgw_pkg::OUT_FRAC - 1);

  lgw_pkg::tok_ctl_t     ctl_a_r;
  lgw_pkg::tok_ctl_t     ctl_b_r;
  logic signed [FW-1:0]  f_a_r [N];
  logic signed [FW-1:0]  f_b_r [N];
  logic signed [LW-1:0]  lane_a_r [N];
  logic signed [LW-1:0]  lane_b_r [N];
  logic                  act_a_r [N];
  logic signed [PHW-1:0] ph_a_r [N];
  logic signed [PLW-1:0] pl_a_r [N];

  logic                  act_nxt [N];
  logic signed [PHW-1:0] ph_nxt [N];
  logic signed [PLW-1:0] pl_nxt [N];
  logic signed [LW-1:0]  lane_nxt [N];
  logic signed [LH-1:0]  hi;
  logic signed [LL:0]    lo;
  logic signed [PW-1:0]  acc;

  // Stage A: split the lane word and form both partial products.
  // A lane skips this factor for its own node, its skipped node and beyond the degree.
  always_comb begin
    hi = '0;
    lo = '0;
    for (int j = 0; j < N; j++) begin
      act_nxt[j] = ctl_in.vld && (ctl_in.idx != lgw_pkg::IDX_W'(K)) &&
                   (lgw_pkg::IDX_W'(j) != lgw_pkg::IDX_W'(K)) &&
                   (lgw_pkg::DEG_W'(K) <= ctl_in.deg);
      hi        = lane_in[j][LW-1:LL];
      lo        = $signed({1'b0, lane_in[j][LL-1:0]});
      ph_nxt[j] = PHW'(hi) * PHW'(f_in[K]);
      pl_nxt[j] = PLW'(lo) * PLW'(f_in[K]);
    end
  end

  // Stage B: recombine, round half up back to Q.20.
  always_comb begin
    acc = '0;
    for (int j = 0; j < N; j++) begin
      acc = (PW'(ph_a_r[j]) <<< LL) + PW'(pl_a_r[j]) + RND_C;
      lane_nxt[j] = act_a_r[j] ?
                    $signed(acc[LW+lgw_pkg::OUT_FRAC-1:lgw_pkg::OUT_FRAC]) : lane_a_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else if (adv) begin
      ctl_a_r <= ctl_in;
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_a_r    <= f_in;
      lane_a_r <= lane_in;
      act_a_r  <= act_nxt;
      ph_a_r   <= ph_nxt;
      pl_a_r   <= pl_nxt;
      f_b_r    <= f_a_r;
      lane_b_r <= lane_nxt;
    end
  end

  assign ctl_out  = ctl_b_r;
  assign f_out    = f_b_r;
  assign lane_out = lane_b_r;

endmodule

[design/lgw_out.sv]
// Result stages: derivative sum, clamp, reciprocal scaling, rounding and saturation.
module lgw_out #(
  parameter int N  = 6,
  parameter int LW = 42
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  lgw_pkg::tok_ctl_t                 ctl_in,
  input  logic signed [LW-1:0]              lane_in [N],
  output logic                              out_vld,
  output logic [lgw_pkg::IDX_W-1:0]         out_idx,
  output logic                              out_last,
  output logic signed [lgw_pkg::RES_W-1:0]  out_weight,
  output logic signed [lgw_pkg::RES_W-1:0]  out_slope
);

  localparam int NP  = (N + 1) / 2;
  localparam int DW  = LW + 3;
  localparam int CW  = lgw_pkg::CLAMP_W;
  localparam int XW  = (DW > CW) ? DW : CW;
  localparam int PRW = CW + lgw_pkg::RECIP_W;
  localparam int RW  = PRW - lgw_pkg::OUT_FRAC;

  localparam logic signed [XW-1:0]  LIM_P  = XW'(64'sd4294967296);
  localparam logic signed [XW-1:0]  LIM_N  = -LIM_P;
  localparam logic signed [PRW-1:0] RND_C  = PRW'(1) <<< (lgw_pkg::OUT_FRAC - 1);
  localparam logic signed [RW-1:0]  SAT_HI = RW'(32'sh7fff_ffff);
  localparam logic signed [RW-1:0]  SAT_LO = RW'(signed'(32'h8000_0000));

  lgw_pkg::tok_ctl_t ctl1_r;
  lgw_pkg::tok_ctl_t ctl2_r;
  lgw_pkg::tok_ctl_t ctl3_r;
  logic signed [LW-1:0]              nom1_r;
  logic signed [LW:0]                psum1_r [NP];
  logic signed [CW-1:0]              nomc2_r;
  logic signed [CW-1:0]              dnomc2_r;
  logic signed [lgw_pkg::RECIP_W-1:0] r2_r;
  logic signed [PRW-1:0]             pw3_r;
  logic signed [PRW-1:0]             pd3_r;
  logic                              vld4_r;
  logic [lgw_pkg::IDX_W-1:0]         idx4_r;
  logic                              last4_r;
  logic signed [lgw_pkg::RES_W-1:0]  wgt4_r;
  logic signed [lgw_pkg::RES_W-1:0]  slp4_r;

  logic signed [LW-1:0] msk [N];
  logic signed [LW-1:0] nom_nxt;
  logic signed [LW:0]   psum_nxt [NP];
  logic signed [XW-1:0] dnom;
  logic signed [XW-1:0] nomx;

  function automatic logic signed [XW-1:0] clamp_lim(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] res;
    if (v > LIM_P) begin
      res = LIM_P;
    end else if (v < LIM_N) begin
      res = LIM_N;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic signed [lgw_pkg::RES_W-1:0] sat_rnd(
    input logic signed [PRW-1:0] p
  );
    logic signed [PRW-1:0] t;
    logic signed [RW-1:0]  q;
    logic signed [lgw_pkg::RES_W-1:0] res;
    t = p + RND_C;
    q = RW'(t >>> lgw_pkg::OUT_FRAC);
    if (q > SAT_HI) begin
      res = 32'sh7fff_ffff;
    end else if (q < SAT_LO) begin
      res = signed'(32'h8000_0000);
    end else begin
      res = q[lgw_pkg::RES_W-1:0];
    end
    return res;
  endfunction

  // Stage 1: pick the node's own lane, mask the others and add them in pairs.
  always_comb begin
    nom_nxt = '0;
    for (int j = 0; j < N; j++) begin
      if (lgw_pkg::IDX_W'(j) == ctl_in.idx) begin
        nom_nxt = nom_nxt | lane_in[j];
      end
      msk[j] = ((lgw_pkg::IDX_W'(j) != ctl_in.idx) && (lgw_pkg::DEG_W'(j) <= ctl_in.deg)) ?
               lane_in[j] : '0;
    end
    for (int p = 0; p < NP; p++) begin
      if (2 * p + 1 < N) begin
        psum_nxt[p] = (LW+1)'(msk[2*p]) + (LW+1)'(msk[2*p+1]);
      end else begin
        psum_nxt[p] = (LW+1)'(msk[2*p]);
      end
    end
  end

  // Stage 2: finish the sum and clamp both numerators.
  always_comb begin
    dnom = '0;
    for (int p = 0; p < NP; p++) begin
      dnom = dnom + XW'(psum1_r[p]);
    end
    nomx = XW'(nom1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      vld4_r <= 1'b0;
    end else if (adv) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      vld4_r <= ctl3_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nom1_r   <= nom_nxt;
      psum1_r  <= psum_nxt;
      nomc2_r  <= CW'(clamp_lim(nomx));
      dnomc2_r <= CW'(clamp_lim(dnom));
      r2_r     <= $signed(lgw_pkg::RECIP_TBL[ctl1_r.deg][ctl1_r.idx]);
      pw3_r    <= PRW'(nomc2_r) * PRW'(r2_r);
      pd3_r    <= PRW'(dnomc2_r) * PRW'(r2_r);
      idx4_r   <= ctl3_r.idx;
      last4_r  <= ctl3_r.last;
      wgt4_r   <= sat_rnd(pw3_r);
      slp4_r   <= sat_rnd(pd3_r);
    end
  end

  assign out_vld    = vld4_r;
  assign out_idx    = idx4_r;
  assign out_last   = last4_r;
  assign out_weight = wgt4_r;
  assign out_slope  = slp4_r;

endmodule

[design/lagrange_basis_weights_core.sv]
// Throughput: degree+1 result beats per point, one per cycle; the node sequencer at the
//   intake issues one node a cycle and takes the next point with the last node.
// A stalled result beat freezes the whole cell chain; the intake still fills when empty.
// Reset (rst_n low, synchronous) clears all valid bits and sets degree to 2; no clear pass.
// Top level of the Lagrange basis weight core on Gauss-Lobatto nodes.
`include "lagrange_basis_weights_core_assert.svh"

module lagrange_basis_weights_core #(
  parameter int MAX_DEGREE = 5,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Point beats
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lgw_pkg::IN_TDATA_W-1:0]     in_tdata,   // [19:0] point, [23:20] zero
  // Result beats
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lgw_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [2:0] node_index,
                                                         // [34:3] weight,
                                                         // [66:35] slope, [71:67] zero
  output logic                               out_tlast,
  // Degree register
  input  logic                               cfg_wr_en,
  input  logic [lgw_pkg::DEG_W-1:0]          cfg_wr_data
);

  // Factor and lane widths follow the point format and the largest degree:
  // each factor is s - x_k in Q.20, each lane a product of up to MAX_DEGREE factors.
  localparam int N    = MAX_DEGREE + 1;
  localparam int S20W = (FRAC_BITS <= lgw_pkg::OUT_FRAC) ? 40 - FRAC_BITS : 41 - FRAC_BITS;
  localparam int FW   = (S20W >= 22) ? S20W + 1 : 22;
  localparam int LW   = MAX_DEGREE * (FW - 21) + 22;
  localparam logic signed [LW-1:0] LANE_ONE = LW'(1) <<< lgw_pkg::OUT_FRAC;

  logic [lgw_pkg::DEG_W-1:0]         deg_cfg_r;
  logic                              adv;
  lgw_pkg::tok_ctl_t                 ctl_c [N+1];
  logic signed [FW-1:0]              f_c [N][N];
  logic signed [LW-1:0]              lane_c [N+1][N];
  logic [lgw_pkg::IDX_W-1:0]         res_idx;
  logic signed [lgw_pkg::RES_W-1:0]  res_wgt;
  logic signed [lgw_pkg::RES_W-1:0]  res_slp;

  // Degree register; the user must write it only while the core is idle, the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_cfg_r <= lgw_pkg::DEG_RESET;
    end else if (cfg_wr_en) begin
      deg_cfg_r <= cfg_wr_data;
    end
  end

  // Advance the whole chain whenever the result register is empty or being taken.
  assign adv = !out_tvalid || out_tready;

  lgw_issue #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS),
    .N          (N),
    .S20W       (S20W),
    .FW         (FW)
  ) u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_point  (in_tdata[lgw_pkg::POINT_W-1:0]),
    .degree    (deg_cfg_r),
    .ctl_out   (ctl_c[0]),
    .f_out     (f_c[0])
  );

  // Every lane starts at 1.0; lane j ends as the product skipping node j,
  // and the lane of the node itself is its basis numerator.
  for (genvar j = 0; j < N; j++) begin : g_lane_one
    assign lane_c[0][j] = LANE_ONE;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k < N - 1) begin : g_mid
      lgw_cell #(.K(k), .N(N), .FW(FW), .LW(LW)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_in   (ctl_c[k]),
        .f_in     (f_c[k]),
        .lane_in  (lane_c[k]),
        .ctl_out  (ctl_c[k+1]),
        .f_out    (f_c[k+1]),
        .lane_out (lane_c[k+1])
      );
    end else begin : g_end
      // Drop the factors after the final cell.
      lgw_cell #(.K(k), .N(N), .FW(FW), .LW(LW)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_in   (ctl_c[k]),
        .f_in     (f_c[k]),
        .lane_in  (lane_c[k]),
        .ctl_out  (ctl_c[k+1]),
        .f_out    (),
        .lane_out (lane_c[k+1])
      );
    end
  end

  lgw_out #(.N(N), .LW(LW)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .ctl_in     (ctl_c[N]),
    .lane_in    (lane_c[N]),
    .out_vld    (out_tvalid),
    .out_idx    (res_idx),
    .out_last   (out_tlast),
    .out_weight (res_wgt),
    .out_slope  (res_slp)
  );

  assign out_tdata = {5'd0, res_slp, res_wgt, res_idx};

  // Nodes of one point leave back to back: a taken non-final beat is followed
  // at once by the next node.
  `LGW_ASSERT_NXT(a_node_seq, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[2:0] == $past(out_tdata[2:0]) + 3'd1), "node results not contiguous")

  // A new point lands on a busy sequencer only while the chain moves.
  `LGW_ASSERT_IMP(a_take_busy, clk, rst_n, in_tvalid && in_tready && ctl_c[0].vld, adv, "point taken while chain stalled")

  // A single-node result is the constant basis: weight 1.0, slope 0.
  `LGW_ASSERT_IMP(a_deg_zero, clk, rst_n, out_tvalid && out_tlast && (out_tdata[2:0] == 3'd0), (out_tdata[34:3] == 32'h0010_0000) && (out_tdata[66:35] == 32'd0), "degree zero result wrong")

endmodule
